>>> rtl/jsu_pkg.sv
// Shared types, character codes and helper functions for the JSON string unescaper.
// No dependencies; imported by json_string_unescape_utf8.
package jsu_pkg;

    // Most output bytes one input transfer can give rise to.
    localparam int MAX_RES = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_NUM_W = $clog2(MAX_RES + 1);

    // Character codes.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // UTF-8 framing.
    localparam logic [15:0] UTF8_LIM1 = 16'h0080;
    localparam logic [15:0] UTF8_LIM2 = 16'h0800;
    localparam logic [7:0]  UTF8_CONT = 8'h80;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_MASK6 = 8'h3F;

    typedef logic [MAX_RES-1:0][7:0] obytes_t;

    typedef struct packed {
        logic       known;
        logic [7:0] code;
    } esc_t;

    // Value of one hex digit; anything else counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'h0;
        if (c inside {[8'h30:8'h39]}) begin
            v = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            v = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

    // Single-character escapes (the u escape is handled by the caller).
    function automatic esc_t esc_lookup(input logic [7:0] c);
        esc_t e;
        e.known = 1'b1;
        case (c)
            CH_QUOTE: e.code = CH_QUOTE;
            CH_BSL:   e.code = CH_BSL;
            CH_B:     e.code = CH_BS;
            CH_F:     e.code = CH_FF;
            CH_N:     e.code = CH_LF;
            CH_R:     e.code = CH_CR;
            CH_T:     e.code = CH_TAB;
            default: begin
                e.known = 1'b0;
                e.code  = c;
            end
        endcase
        return e;
    endfunction

    // Append one byte to a result group; bytes beyond the group size are dropped.
    function automatic void put_byte(inout obytes_t ob, inout logic [RES_NUM_W-1:0] n,
                                     input logic [7:0] b);
        if (n < RES_NUM_W'(MAX_RES)) begin
            ob[n[RES_IDX_W-1:0]] = b;
            n = n + RES_NUM_W'(1);
        end
    endfunction

endpackage

>>> rtl/json_string_unescape_utf8.sv
// JSON string-body unescaper: raw bytes in, unescaped UTF-8 bytes out.
// Result bytes are registered in the group buffer before they are shown on m_*.
// Throughput: 1 input transfer per cycle unless a group is pending; bytes leave one at a time.
// A two-deep group buffer (draining group plus one pending) sets how far input runs ahead.
// Reset: aresetn synchronous, active low; returns to plain text with empty buffers.
// Depends on jsu_pkg.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);

    // Parser phase: plain text, just after a backslash, inside the four digits of \u.
    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_BACK  = 2'd1,
        PH_HEX   = 2'd2
    } phase_t;

    // One group of result bytes from a single input transfer.
    typedef struct packed {
        obytes_t                bytes;
        logic [RES_IDX_W-1:0]   top;    // index of the final byte
        logic                   last;   // group ends the string
    } group_t;

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    phase_t      phase_reg, phase_next;
    logic [1:0]  dcnt_reg, dcnt_next;       // hex digits held so far
    logic [11:0] cp_reg, cp_next;           // value of up to three held digits
    // Only the first two held digits can ever be replayed: a third one is
    // always followed by the fourth, completing the escape.
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;

    // ---------------------------------------------------------------
    // Output group buffer: A drains onto m_*, B waits behind it
    // ---------------------------------------------------------------
    group_t               a_grp_reg, a_grp_next;
    logic                 a_valid_reg, a_valid_next;
    logic [RES_IDX_W-1:0] a_idx_reg, a_idx_next;
    group_t               b_grp_reg, b_grp_next;
    logic                 b_valid_reg, b_valid_next;

    logic                 s_fire;
    logic                 a_free;
    obytes_t              res_bytes;
    logic [RES_NUM_W-1:0] res_num;
    group_t               res_grp;

    assign s_tready = !b_valid_reg;
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid = a_valid_reg;
    assign m_tdata  = a_grp_reg.bytes[a_idx_reg];
    assign m_tlast  = a_grp_reg.last && (a_idx_reg == a_grp_reg.top);

    // A is free for a new group when empty or when its final byte leaves now.
    assign a_free = !a_valid_reg || (m_tready && (a_idx_reg == a_grp_reg.top));

    // ---------------------------------------------------------------
    // Unescape step for one accepted byte
    // ---------------------------------------------------------------
    always_comb begin
        esc_t        esc;
        phase_t      rp;
        logic [7:0]  x;
        logic [15:0] cpw;
        obytes_t     ob;
        logic [RES_NUM_W-1:0] n;

        esc = '0;
        rp  = PH_PLAIN;
        x   = 8'h00;
        cpw = 16'h0000;
        ob  = '0;
        n   = '0;

        phase_next = phase_reg;
        dcnt_next  = dcnt_reg;
        cp_next    = cp_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;

        if (s_fire) begin
            case (phase_reg)
                PH_BACK: begin
                    phase_next = PH_PLAIN;
                    esc = esc_lookup(s_tdata);
                    if (esc.known) begin
                        put_byte(ob, n, esc.code);
                    end else if (s_tdata == CH_U) begin
                        if (s_tlast) begin
                            put_byte(ob, n, CH_U);
                        end else begin
                            phase_next = PH_HEX;
                            dcnt_next  = 2'd0;
                            cp_next    = 12'h000;
                        end
                    end else begin
                        // unknown escape keeps its backslash
                        put_byte(ob, n, CH_BSL);
                        put_byte(ob, n, s_tdata);
                    end
                end
                PH_HEX: begin
                    if (dcnt_reg == 2'd3) begin
                        // fourth digit: emit the code point as UTF-8
                        cpw = {cp_reg, hex_value(s_tdata)};
                        phase_next = PH_PLAIN;
                        dcnt_next  = 2'd0;
                        cp_next    = 12'h000;
                        if (cpw < UTF8_LIM1) begin
                            put_byte(ob, n, cpw[7:0]);
                        end else if (cpw < UTF8_LIM2) begin
                            put_byte(ob, n, UTF8_LEAD2 | {3'b000, cpw[10:6]});
                            put_byte(ob, n, UTF8_CONT | (cpw[7:0] & UTF8_MASK6));
                        end else begin
                            put_byte(ob, n, UTF8_LEAD3 | {4'h0, cpw[15:12]});
                            put_byte(ob, n, UTF8_CONT | ({2'b00, cpw[11:6]} & UTF8_MASK6));
                            put_byte(ob, n, UTF8_CONT | (cpw[7:0] & UTF8_MASK6));
                        end
                    end else if (s_tlast) begin
                        // cut-off \u: drop the backslash, emit u, then run the held
                        // digits and this byte again as plain text
                        phase_next = PH_PLAIN;
                        dcnt_next  = 2'd0;
                        cp_next    = 12'h000;
                        put_byte(ob, n, CH_U);
                        for (int k = 0; k < 2; k++) begin
                            if (k < int'(dcnt_reg)) begin
                                x = (k == 0) ? held0_reg : held1_reg;
                                case (rp)
                                    PH_BACK: begin
                                        rp  = PH_PLAIN;
                                        esc = esc_lookup(x);
                                        if (esc.known) begin
                                            put_byte(ob, n, esc.code);
                                        end else if (x == CH_U) begin
                                            rp = PH_HEX;
                                        end else begin
                                            put_byte(ob, n, CH_BSL);
                                            put_byte(ob, n, x);
                                        end
                                    end
                                    default: begin
                                        if (x == CH_BSL) begin
                                            rp = PH_BACK;
                                        end else begin
                                            put_byte(ob, n, x);
                                        end
                                    end
                                endcase
                            end
                        end
                        // final byte, string end
                        case (rp)
                            PH_BACK: begin
                                esc = esc_lookup(s_tdata);
                                if (esc.known) begin
                                    put_byte(ob, n, esc.code);
                                end else if (s_tdata == CH_U) begin
                                    put_byte(ob, n, CH_U);
                                end else begin
                                    put_byte(ob, n, CH_BSL);
                                    put_byte(ob, n, s_tdata);
                                end
                            end
                            PH_HEX: begin
                                // nested cut-off \u with no digits held
                                put_byte(ob, n, CH_U);
                                put_byte(ob, n, s_tdata);
                            end
                            default: begin
                                put_byte(ob, n, s_tdata);
                            end
                        endcase
                    end else begin
                        // hold a digit
                        if (dcnt_reg == 2'd0) begin
                            held0_next = s_tdata;
                        end
                        if (dcnt_reg == 2'd1) begin
                            held1_next = s_tdata;
                        end
                        cp_next   = {cp_reg[7:0], hex_value(s_tdata)};
                        dcnt_next = dcnt_reg + 2'd1;
                    end
                end
                default: begin
                    phase_next = PH_PLAIN;
                    if (s_tdata == CH_BSL) begin
                        if (s_tlast) begin
                            put_byte(ob, n, CH_BSL);
                        end else begin
                            phase_next = PH_BACK;
                        end
                    end else begin
                        put_byte(ob, n, s_tdata);
                    end
                end
            endcase
        end

        res_bytes = ob;
        res_num   = n;
    end

    assign res_grp.bytes = res_bytes;
    assign res_grp.top   = RES_IDX_W'(res_num - RES_NUM_W'(1));
    assign res_grp.last  = s_tlast;

    // ---------------------------------------------------------------
    // Group buffer control
    // ---------------------------------------------------------------
    always_comb begin
        a_grp_next   = a_grp_reg;
        a_valid_next = a_valid_reg;
        a_idx_next   = a_idx_reg;
        b_grp_next   = b_grp_reg;
        b_valid_next = b_valid_reg;

        if (a_free) begin
            a_idx_next = '0;
            if (b_valid_reg) begin
                a_grp_next   = b_grp_reg;
                a_valid_next = 1'b1;
                b_valid_next = 1'b0;
                if (s_fire && (res_num != '0)) begin
                    b_grp_next   = res_grp;
                    b_valid_next = 1'b1;
                end
            end else if (s_fire && (res_num != '0)) begin
                a_grp_next   = res_grp;
                a_valid_next = 1'b1;
            end else begin
                a_valid_next = 1'b0;
            end
        end else begin
            if (m_tready) begin
                a_idx_next = a_idx_reg + RES_IDX_W'(1);
            end
            if (s_fire && (res_num != '0)) begin
                b_grp_next   = res_grp;
                b_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_PLAIN;
            dcnt_reg    <= 2'd0;
            cp_reg      <= 12'h000;
            a_valid_reg <= 1'b0;
            a_idx_reg   <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            dcnt_reg    <= dcnt_next;
            cp_reg      <= cp_next;
            a_valid_reg <= a_valid_next;
            a_idx_reg   <= a_idx_next;
            b_valid_reg <= b_valid_next;
        end
        held0_reg <= held0_next;
        held1_reg <= held1_next;
        a_grp_reg <= a_grp_next;
        b_grp_reg <= b_grp_next;
    end

endmodule

>>> sim/json_string_unescape_utf8_test.sv
// Self-checking testbench for json_string_unescape_utf8: directed and random string bodies.
// An own unescaper predicts the output bytes, which are checked in order against the result stream.
// Depends on jsu_pkg and json_string_unescape_utf8 in rtl.
module json_string_unescape_utf8_test;

    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    // Extra character codes used to build and decode hex digits.
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_F = 8'h46;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_F = 8'h66;
    localparam logic [7:0] CH_Q    = 8'h71;   // 'q', not a JSON escape

    localparam logic [7:0]  SIMPLE_ESC [7] = '{CH_QUOTE, CH_BSL, CH_B, CH_F, CH_N, CH_R, CH_T};
    // Code points at the borders of the one, two and three byte UTF-8 forms.
    localparam logic [15:0] CP_BOUNDS [6] = '{16'h0000, 16'h007F, 16'h0080,
                                              16'h07FF, 16'h0800, 16'hFFFF};

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 300;    // receiver hold-off in the pressure test
    localparam int unsigned DRAIN_WAIT  = 16;     // wait for stray bytes past the two-deep buffer

    typedef enum logic [1:0] {
        SCAN_TEXT,      // plain string text
        SCAN_ESCAPE,    // a backslash has been seen
        SCAN_HEX,       // inside the four digits of a backslash-u
        SCAN_UNUSED     // never entered, behaves as plain text
    } scan_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    typedef logic [7:0] byte_q_t [$];

    // ---------------------------------------------------------------- clock, reset, ports
    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    always #10 aclk = ~aclk;

    json_string_unescape_utf8 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] in_byte
        .s_tlast  (s_tlast),   // in_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] out_byte
        .m_tlast  (m_tlast)    // out_last
    );

    // ---------------------------------------------------------------- unescaper state
    scan_state_t scan_state  = SCAN_TEXT;
    logic [1:0]  digits_held = 2'd0;
    logic [15:0] code_acc    = 16'h0000;
    logic [7:0]  held_bytes [3];

    out_byte_t   step_bytes [$];     // bytes given by the transfer being predicted
    out_byte_t   unescaped_due [$];  // predicted bytes not yet seen on the result stream

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // Idling controls for the sender task (gaps) and the receiver process (stalls, hold-off).
    bit          gaps_on    = 1'b1;
    bit          stalls_on  = 1'b1;
    int unsigned long_hold  = 0;
    int unsigned stall_left = 0;

    // ---------------------------------------------------------------- prediction
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c[3:0];
        // 'A'..'F' and 'a'..'f' both carry 1..6 in the low nibble
        if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F))
            return c[3:0] + 4'd9;
        return 4'h0;   // non-hex digits count as zero
    endfunction

    // At most MAX_RES bytes per transfer; anything past that is lost.
    function automatic void put_out(input logic [7:0] b);
        if (step_bytes.size() < MAX_RES) step_bytes.push_back('{data: b, last: 1'b0});
    endfunction

    function automatic void put_utf8(input logic [15:0] cp);
        if (cp < UTF8_LIM1) begin
            put_out(cp[7:0]);
        end else if (cp < UTF8_LIM2) begin
            put_out(UTF8_LEAD2 | {3'b000, cp[10:6]});
            put_out(UTF8_CONT | {2'b00, cp[5:0]});
        end else begin
            put_out(UTF8_LEAD3 | {4'b0000, cp[15:12]});
            put_out(UTF8_CONT | {2'b00, cp[11:6]});
            put_out(UTF8_CONT | {2'b00, cp[5:0]});
        end
    endfunction

    // One raw byte through the unescaper. Recursive: a backslash-u cut off by
    // the end of the string replays its held digits and the last byte as text.
    function automatic void unescape_byte(input logic [7:0] b, input logic l);
        logic [7:0]  tail [3];
        int unsigned n;
        int unsigned k;
        case (scan_state)
            SCAN_ESCAPE: begin
                scan_state = SCAN_TEXT;
                case (b)
                    CH_QUOTE: put_out(CH_QUOTE);
                    CH_BSL:   put_out(CH_BSL);
                    CH_B:     put_out(CH_BS);
                    CH_F:     put_out(CH_FF);
                    CH_N:     put_out(CH_LF);
                    CH_R:     put_out(CH_CR);
                    CH_T:     put_out(CH_TAB);
                    CH_U: begin
                        if (l) begin
                            put_out(CH_U);
                        end else begin
                            scan_state  = SCAN_HEX;
                            digits_held = 2'd0;
                            code_acc    = 16'h0000;
                        end
                    end
                    default: begin
                        // unknown escape keeps its backslash
                        put_out(CH_BSL);
                        put_out(b);
                    end
                endcase
            end
            SCAN_HEX: begin
                if (digits_held == 2'd3) begin
                    code_acc = {code_acc[11:0], hex_nibble(b)};
                    put_utf8(code_acc);
                    scan_state  = SCAN_TEXT;
                    digits_held = 2'd0;
                    code_acc    = 16'h0000;
                end else if (l) begin
                    n = digits_held;
                    for (k = 0; k < n; k++) tail[k] = held_bytes[k];
                    scan_state  = SCAN_TEXT;
                    digits_held = 2'd0;
                    code_acc    = 16'h0000;
                    put_out(CH_U);
                    for (k = 0; k < n; k++) unescape_byte(tail[k], 1'b0);
                    unescape_byte(b, 1'b1);
                end else begin
                    held_bytes[digits_held] = b;
                    code_acc    = {code_acc[11:0], hex_nibble(b)};
                    digits_held = digits_held + 2'd1;
                end
            end
            default: begin
                scan_state = SCAN_TEXT;
                if (b == CH_BSL) begin
                    if (l) put_out(CH_BSL);    // backslash at the end stays
                    else scan_state = SCAN_ESCAPE;
                end else begin
                    put_out(b);
                end
            end
        endcase
    endfunction

    // Called once per accepted input transfer.
    function automatic void predict_transfer(input logic [7:0] b, input logic l);
        int unsigned k;
        step_bytes.delete();
        unescape_byte(b, l);
        if (l && step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
        for (k = 0; k < step_bytes.size(); k++) unescaped_due.push_back(step_bytes[k]);
    endfunction

    // ---------------------------------------------------------------- result checking
    function automatic void flag_mismatch(input bit have_want, input out_byte_t want);
        mismatches++;
        if (mismatches <= 10) begin
            if (have_want)
                $display("%0t: mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                         $time, want.data, want.last, m_tdata, m_tlast);
            else
                $display("%0t: mismatch: no byte expected, got byte %02h last %0b",
                         $time, m_tdata, m_tlast);
        end
    endfunction

    out_byte_t next_due;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (unescaped_due.size() == 0) begin
                flag_mismatch(1'b0, '0);
            end else begin
                next_due = unescaped_due.pop_front();
                if (m_tdata !== next_due.data || m_tlast !== next_due.last)
                    flag_mismatch(1'b1, next_due);
            end
        end
    end

    // Run limit, far above the slowest legal run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("json_string_unescape_utf8 regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- receiver
    // One decision per falling edge: a requested long hold-off, a running
    // stall burst, a new burst, or ready.
    always @(negedge aclk) begin
        if (long_hold > 0) begin
            m_tready <= 1'b0;
            long_hold--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(1, 17) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- sender
    // Drives one byte at a falling edge, maybe after a gap, and holds it until
    // the transfer completes at a rising edge. tvalid is never dropped and
    // raised in the same step.
    task automatic send_transfer(input logic [7:0] b, input logic l);
        int unsigned gap;
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        predict_transfer(b, l);
    endtask

    task automatic send_string(input byte_q_t s);
        int unsigned k;
        for (k = 0; k < s.size(); k++) send_transfer(s[k], k == s.size() - 1);
    endtask

    // ---------------------------------------------------------------- string generation
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(v - 4'd10);
    endfunction

    // Mostly well-formed escapes with random content; some noise in the digits,
    // and now and then a string that ends in a bare backslash or a cut-off \u.
    function automatic void make_string(output byte_q_t s);
        int unsigned pieces;
        int unsigned kind;
        int unsigned n;
        int          k;
        logic [15:0] cp;
        s.delete();
        pieces = $urandom_range(1, 8);
        repeat (pieces) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                s.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 55) begin
                s.push_back(CH_BSL);
                s.push_back(SIMPLE_ESC[$urandom_range(0, 6)]);
            end else if (kind < 85) begin
                case ($urandom_range(0, 3))
                    0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
                    1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    default: cp = CP_BOUNDS[$urandom_range(0, 5)];
                endcase
                s.push_back(CH_BSL);
                s.push_back(CH_U);
                for (k = 3; k >= 0; k--) begin
                    if ($urandom_range(0, 19) == 0) s.push_back(8'($urandom_range(0, 255)));
                    else s.push_back(hex_char(cp[k*4 +: 4]));
                end
            end else begin
                // escape of any byte, mostly unknown ones
                s.push_back(CH_BSL);
                s.push_back(8'($urandom_range(0, 255)));
            end
        end
        case ($urandom_range(0, 9))
            0: s.push_back(CH_BSL);
            1, 2: begin
                s.push_back(CH_BSL);
                s.push_back(CH_U);
                n = $urandom_range(0, 3);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0:       s.push_back(CH_BSL);
                        1:       s.push_back(CH_U);
                        default: s.push_back(hex_char(4'($urandom_range(0, 15))));
                    endcase
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- tests
    // Byte extremes, every single-character escape, an unknown escape and a
    // backslash as the last byte, all in one string.
    task automatic test_simple_escapes;
        byte_q_t s;
        int unsigned k;
        s = '{8'h00, 8'hFF};
        for (k = 0; k < 7; k++) begin
            s.push_back(CH_BSL);
            s.push_back(SIMPLE_ESC[k]);
        end
        s.push_back(CH_BSL);
        s.push_back(CH_Q);
        s.push_back(CH_BSL);
        send_string(s);
    endtask

    // A two byte \u escape, then a \u cut off after one digit whose last byte
    // is a backslash, so the replayed text ends in a bare backslash.
    task automatic test_unicode_escapes;
        send_string('{CH_BSL, CH_U, CH_ZERO, CH_ZERO, CH_LO_F - 8'd1, CH_NINE});
        send_string('{CH_BSL, CH_U, CH_ZERO + 8'd1, CH_BSL});
    endtask

    task automatic test_random_strings(input int unsigned budget);
        byte_q_t s;
        int unsigned sent;
        sent = 0;
        while (sent < budget) begin
            // quiet stretches now and then on either side
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            make_string(s);
            send_string(s);
            sent += s.size();
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the output buffer fills and s_tready drops.
    task automatic test_output_backpressure;
        byte_q_t s;
        int unsigned sent;
        sent      = 0;
        gaps_on   = 1'b0;
        long_hold = LONG_HOLD;
        while (sent < 40) begin
            make_string(s);
            send_string(s);
            sent += s.size();
        end
        gaps_on = 1'b1;
    endtask

    // Closing stretch at full rate: no gaps, no stalls.
    task automatic test_full_rate(input int unsigned budget);
        byte_q_t s;
        int unsigned sent;
        sent      = 0;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        while (sent < budget) begin
            make_string(s);
            send_string(s);
            sent += s.size();
        end
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_simple_escapes;
        test_unicode_escapes;
        test_random_strings(200);
        test_output_backpressure;
        test_full_rate(40);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (unescaped_due.size() != 0) @(posedge aclk);
        // catch any stray byte after the last expected one
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0 && unescaped_due.size() == 0) begin
            $display("json_string_unescape_utf8 regression: pass");
        end else begin
            $display("json_string_unescape_utf8 regression: fail");
        end
        $finish;
    end

endmodule
